// File: rtl/core/macdxs_pkg.sv
// ----------------------------------------------------------------------------
// macdxs_pkg
// Types and constants of the MACD crossover signal block: transaction
// payloads, register map and datapath widths.
// ----------------------------------------------------------------------------
package macdxs_pkg;

   localparam int PRICE_W   = 32;
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 8;
   localparam int OUT_W     = 48;
   localparam int FRAC_BITS = 16;
   localparam int PX_W      = PRICE_W + 1;          // signal EMA, DIF and DEA values
   localparam int MC_W      = PX_W + 1;             // multiplicand of a serial product
   localparam int ACC_W     = MC_W + GAIN_W;        // product accumulator
   localparam int MUL_STEPS = GAIN_W;
   localparam int CNT_W     = $clog2(MUL_STEPS);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_FAST_GAIN      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SLOW_GAIN      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SIGNAL_GAIN    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BUY_THRESHOLD  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SELL_THRESHOLD = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_HOLD_LIMIT     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_MARKET_FILTER  = 3'd6;

   localparam logic [GAIN_W-1:0] FAST_GAIN_RESET   = 16'd10082;
   localparam logic [GAIN_W-1:0] SLOW_GAIN_RESET   = 16'd4855;
   localparam logic [GAIN_W-1:0] SIGNAL_GAIN_RESET = 16'd13107;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = 50'sd32768;

   typedef struct packed {
      logic [PRICE_W-1:0] close_price;
      logic               market_above;
      logic               series_start;
      logic               series_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] dif_value;
      logic signed [OUT_W-1:0] dea_value;
      logic                    buy_now;
      logic                    sell_now;
      logic                    sell_by_limit;
   } rsp_payload_type;

endpackage

// File: rtl/core/macd_crossover_signal.sv
// ----------------------------------------------------------------------------
// macd_crossover_signal
// MACD (fast/slow EMA, signal EMA) crossover detector with threshold tests,
// market filter and hold limit, one result transaction per close price.
// ----------------------------------------------------------------------------
// One transaction carries one period close. The first period of a series
// (series_start, or the first transaction after reset) goes from acceptance
// straight to the result load; every other period runs two shift-add
// multipliers that consume the 16-bit gain or threshold one bit per cycle:
// one pass for the fast and slow EMA products, then one pass for the signal
// EMA product and the threshold product; the update steps S_UPD, S_DIF and
// S_SETUP lie between the passes, S_FIN and S_DONE after them. The result
// sits in an output register, so the next transaction is accepted while a
// result still waits on rsp_ready. Registers lie at byte address 4*index on
// the APB port and read back their value.
// ----------------------------------------------------------------------------
module macd_crossover_signal
   import macdxs_pkg::*;
#(
   parameter int HOLD_COUNT_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CMP_W = (HOLD_COUNT_BITS > LIMIT_W) ? HOLD_COUNT_BITS : LIMIT_W;
   localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = {HOLD_COUNT_BITS{1'b1}};
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EMA   = 3'd1;
   localparam logic [2:0] S_UPD   = 3'd2;
   localparam logic [2:0] S_DIF   = 3'd3;
   localparam logic [2:0] S_SETUP = 3'd4;
   localparam logic [2:0] S_SIG   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [1:0] PH_EMPTY  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_RUN    = 2'd2;

   // configuration
   logic [GAIN_W-1:0]         fast_gain_ff, slow_gain_ff, signal_gain_ff;
   logic signed [GAIN_W-1:0]  buy_thr_ff, sell_thr_ff;
   logic [LIMIT_W-1:0]        hold_limit_ff;
   logic                      mkt_filter_ff;
   logic                      csr_wr;
   logic [REG_IDX_W-1:0]      csr_idx;

   // control and state
   logic [2:0]                state_ff, state_in;
   logic [1:0]                phase_ff, phase_in;
   logic                      in_pos_ff, in_pos_in;
   logic [HOLD_COUNT_BITS-1:0] hold_ff, hold_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   // datapath
   logic [PRICE_W-1:0]        close_ff, close_in;
   logic                      mkt_ff, mkt_in;
   logic                      last_ff, last_in;
   logic                      first_ff, first_in;
   logic [PRICE_W-1:0]        fast_ff, fast_in, slow_ff, slow_in;
   logic signed [PX_W-1:0]    signal_ff, signal_in;
   logic signed [PX_W-1:0]    prev_dif_ff, prev_dif_in, prev_dea_ff, prev_dea_in;
   logic signed [PX_W-1:0]    dif_ff, dif_in, dea_ff, dea_in;
   logic                      lvl_lt_ff, lvl_lt_in, lvl_gt_ff, lvl_gt_in;
   logic signed [ACC_W-1:0]   acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic signed [MC_W-1:0]    mcand_a_ff, mcand_a_in, mcand_b_ff, mcand_b_in;
   logic [GAIN_W-1:0]         mplier_a_ff, mplier_a_in, mplier_b_ff, mplier_b_in;
   logic                      neg_b_ff, neg_b_in;
   rsp_payload_type           rsp_ff, rsp_in;

   function automatic logic signed [MC_W-1:0] round_q16(input logic signed [ACC_W-1:0] p);
      logic signed [ACC_W-1:0] q;
      q = p + ROUND_HALF;
      return q[ACC_W-1:FRAC_BITS];
   endfunction

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      unique case (csr_idx)
         REG_FAST_GAIN:      csr_prdata = CSR_DATA_W'(fast_gain_ff);
         REG_SLOW_GAIN:      csr_prdata = CSR_DATA_W'(slow_gain_ff);
         REG_SIGNAL_GAIN:    csr_prdata = CSR_DATA_W'(signal_gain_ff);
         REG_BUY_THRESHOLD:  csr_prdata = CSR_DATA_W'(unsigned'(buy_thr_ff));
         REG_SELL_THRESHOLD: csr_prdata = CSR_DATA_W'(unsigned'(sell_thr_ff));
         REG_HOLD_LIMIT:     csr_prdata = CSR_DATA_W'(hold_limit_ff);
         REG_MARKET_FILTER:  csr_prdata = CSR_DATA_W'(mkt_filter_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_gain_ff   <= FAST_GAIN_RESET;
         slow_gain_ff   <= SLOW_GAIN_RESET;
         signal_gain_ff <= SIGNAL_GAIN_RESET;
         buy_thr_ff     <= '0;
         sell_thr_ff    <= '0;
         hold_limit_ff  <= '0;
         mkt_filter_ff  <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FAST_GAIN:      fast_gain_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_SLOW_GAIN:      slow_gain_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_SIGNAL_GAIN:    signal_gain_ff <= csr_pwdata[GAIN_W-1:0];
            REG_BUY_THRESHOLD:  buy_thr_ff     <= signed'(csr_pwdata[GAIN_W-1:0]);
            REG_SELL_THRESHOLD: sell_thr_ff    <= signed'(csr_pwdata[GAIN_W-1:0]);
            REG_HOLD_LIMIT:     hold_limit_ff  <= csr_pwdata[LIMIT_W-1:0];
            REG_MARKET_FILTER:  mkt_filter_ff  <= csr_pwdata[0];
            default:            ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic signed [ACC_W-1:0] add_a, add_b, shl_a, shl_b;
      logic signed [ACC_W-1:0] lhs;
      logic signed [MC_W-1:0]  sum;
      logic                    cross_buy, cross_sell, forced, buy, sell, active;
      logic [CMP_W-1:0]        hold_ext, limit_ext;
      logic [HOLD_COUNT_BITS-1:0] hold_next;
      logic                    pos_next;

      state_in     = state_ff;
      phase_in     = phase_ff;
      in_pos_in    = in_pos_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cnt_in       = cnt_ff;
      close_in     = close_ff;
      mkt_in       = mkt_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      signal_in    = signal_ff;
      prev_dif_in  = prev_dif_ff;
      prev_dea_in  = prev_dea_ff;
      dif_in       = dif_ff;
      dea_in       = dea_ff;
      lvl_lt_in    = lvl_lt_ff;
      lvl_gt_in    = lvl_gt_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      mcand_a_in   = mcand_a_ff;
      mcand_b_in   = mcand_b_ff;
      mplier_a_in  = mplier_a_ff;
      mplier_b_in  = mplier_b_ff;
      neg_b_in     = neg_b_ff;
      rsp_in       = rsp_ff;

      // one multiplier bit per cycle, most significant first
      add_a = mplier_a_ff[GAIN_W-1] ? ACC_W'(mcand_a_ff) : '0;
      add_b = mplier_b_ff[GAIN_W-1] ? ACC_W'(mcand_b_ff) : '0;
      shl_a = acc_a_ff <<< 1;
      shl_b = acc_b_ff <<< 1;
      lhs   = ACC_W'(dif_ff) <<< FRAC_BITS;
      sum   = '0;

      cross_buy  = (prev_dif_ff <= prev_dea_ff) && (dif_ff > dea_ff);
      cross_sell = (prev_dif_ff >= prev_dea_ff) && (dif_ff < dea_ff);
      hold_ext   = CMP_W'(hold_ff);
      limit_ext  = CMP_W'(hold_limit_ff);
      active     = !first_ff && !last_ff;
      forced     = (hold_limit_ff != '0) && (hold_ext >= limit_ext);
      buy        = active && !in_pos_ff && cross_buy && lvl_lt_ff && (!mkt_filter_ff || mkt_ff);
      sell       = active && in_pos_ff && ((cross_sell && lvl_gt_ff) || forced);
      pos_next   = buy ? 1'b1 : (sell ? 1'b0 : in_pos_ff);
      hold_next  = (buy || sell) ? '0 : hold_ff;
      if (pos_next && !buy && (hold_next != HOLD_MAX)) begin
         hold_next = hold_next + HOLD_COUNT_BITS'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               close_in    = req_data.close_price;
               mkt_in      = req_data.market_above;
               last_in     = req_data.series_last;
               first_in    = req_data.series_start || (phase_ff == PH_EMPTY);
               mcand_a_in  = MC_W'({1'b0, req_data.close_price}) - MC_W'({1'b0, fast_ff});
               mcand_b_in  = MC_W'({1'b0, req_data.close_price}) - MC_W'({1'b0, slow_ff});
               mplier_a_in = fast_gain_ff;
               mplier_b_in = slow_gain_ff;
               neg_b_in    = 1'b0;
               acc_a_in    = '0;
               acc_b_in    = '0;
               cnt_in      = '0;
               state_in    = (req_data.series_start || (phase_ff == PH_EMPTY)) ?
                             S_DONE : S_EMA;
            end
         end
         S_EMA, S_SIG: begin
            acc_a_in    = shl_a + add_a;
            acc_b_in    = (neg_b_ff && (cnt_ff == '0)) ? (shl_b - add_b) : (shl_b + add_b);
            mplier_a_in = mplier_a_ff << 1;
            mplier_b_in = mplier_b_ff << 1;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = (state_ff == S_EMA) ? S_UPD : S_FIN;
            end
         end
         S_UPD: begin
            sum      = MC_W'({1'b0, fast_ff}) + round_q16(acc_a_ff);
            fast_in  = sum[PRICE_W-1:0];
            sum      = MC_W'({1'b0, slow_ff}) + round_q16(acc_b_ff);
            slow_in  = sum[PRICE_W-1:0];
            state_in = S_DIF;
         end
         S_DIF: begin
            dif_in   = PX_W'({1'b0, fast_ff}) - PX_W'({1'b0, slow_ff});
            state_in = S_SETUP;
         end
         S_SETUP: begin
            mcand_a_in  = MC_W'(dif_ff) - MC_W'(signal_ff);
            mcand_b_in  = MC_W'({1'b0, close_ff});
            mplier_a_in = signal_gain_ff;
            mplier_b_in = in_pos_ff ? unsigned'(sell_thr_ff) : unsigned'(buy_thr_ff);
            neg_b_in    = 1'b1;
            acc_a_in    = '0;
            acc_b_in    = '0;
            cnt_in      = '0;
            state_in    = S_SIG;
         end
         S_FIN: begin
            sum       = MC_W'(signal_ff) + round_q16(acc_a_ff);
            dea_in    = (phase_ff == PH_SECOND) ? dif_ff : sum[PX_W-1:0];
            lvl_lt_in = lhs < acc_b_ff;
            lvl_gt_in = lhs > acc_b_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (first_ff) begin
                  fast_in     = close_ff;
                  slow_in     = close_ff;
                  signal_in   = '0;
                  prev_dif_in = '0;
                  prev_dea_in = '0;
                  phase_in    = PH_SECOND;
                  in_pos_in   = 1'b0;
                  hold_in     = '0;
                  rsp_in      = '0;
               end else begin
                  signal_in            = dea_ff;
                  prev_dif_in          = dif_ff;
                  prev_dea_in          = dea_ff;
                  phase_in             = PH_RUN;
                  in_pos_in            = pos_next;
                  hold_in              = hold_next;
                  rsp_in.dif_value     = OUT_W'(dif_ff);
                  rsp_in.dea_value     = OUT_W'(dea_ff);
                  rsp_in.buy_now       = buy;
                  rsp_in.sell_now      = sell;
                  rsp_in.sell_by_limit = sell && forced;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_EMPTY;
         in_pos_ff    <= 1'b0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         in_pos_ff    <= in_pos_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      close_ff    <= close_in;
      mkt_ff      <= mkt_in;
      last_ff     <= last_in;
      first_ff    <= first_in;
      fast_ff     <= fast_in;
      slow_ff     <= slow_in;
      signal_ff   <= signal_in;
      prev_dif_ff <= prev_dif_in;
      prev_dea_ff <= prev_dea_in;
      dif_ff      <= dif_in;
      dea_ff      <= dea_in;
      lvl_lt_ff   <= lvl_lt_in;
      lvl_gt_ff   <= lvl_gt_in;
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      mcand_a_ff  <= mcand_a_in;
      mcand_b_ff  <= mcand_b_in;
      mplier_a_ff <= mplier_a_in;
      mplier_b_ff <= mplier_b_in;
      neg_b_ff    <= neg_b_in;
      rsp_ff      <= rsp_in;
   end

   a_buy_sell_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.buy_now && rsp_data.sell_now))
      else $error("buy and sell in one transaction");

   a_limit_implies_sell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sell_by_limit |-> rsp_data.sell_now)
      else $error("limit exit without sell");

   a_buy_on_cross: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.buy_now |-> rsp_data.dif_value > rsp_data.dea_value)
      else $error("buy without DIF above DEA");

   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> $stable(hold_ff) && $stable(in_pos_ff))
      else $error("position state changed outside result load");

endmodule

// File: dv/macd_crossover_signal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macd_crossover_signal_tb
// Drives close prices through macd_crossover_signal as short and long price
// series, mostly well formed with random walk prices, plus stray start and
// last flags and raw 32-bit closes. A scoreboard keeps its own EMA, DIF/DEA
// and position state, predicts DIF, DEA and the buy/sell flags of every
// accepted close, and compares each result with the oldest prediction. The
// register set is rewritten between phases while the block is idle, over
// extreme, default and random settings.
// ----------------------------------------------------------------------------
module macd_crossover_signal_tb
   import macdxs_pkg::*;
;

   localparam int HOLD_COUNT_BITS = 8;
   localparam int HOLD_MAX = (1 << HOLD_COUNT_BITS) - 1;
   localparam int LIMIT_CYCLES = 600000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 135;
   localparam longint PRICE_MAX = 64'h0000_0000_FFFF_FFFF;
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_FIRST,
      PHASE_RUN
   } series_phase_type;

   class macd_signal_scoreboard;
      longint gain_fast, gain_slow, gain_signal, buy_level, sell_level;
      int hold_limit;
      bit market_filter;
      longint fast_ema, slow_ema, signal_ema, prior_dif, prior_dea;
      series_phase_type phase;
      bit holding;
      int hold_count;
      rsp_payload_type expected_signals[$];
      int results_seen;
      int mismatches;

      function new();
         gain_fast = longint'(FAST_GAIN_RESET);
         gain_slow = longint'(SLOW_GAIN_RESET);
         gain_signal = longint'(SIGNAL_GAIN_RESET);
         buy_level = 0;
         sell_level = 0;
         hold_limit = 0;
         market_filter = 1'b0;
         fast_ema = 0;
         slow_ema = 0;
         signal_ema = 0;
         prior_dif = 0;
         prior_dea = 0;
         phase = PHASE_IDLE;
         holding = 1'b0;
         hold_count = 0;
         results_seen = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_FAST_GAIN:      gain_fast = longint'(value[GAIN_W-1:0]);
            REG_SLOW_GAIN:      gain_slow = longint'(value[GAIN_W-1:0]);
            REG_SIGNAL_GAIN:    gain_signal = longint'(value[GAIN_W-1:0]);
            REG_BUY_THRESHOLD:  buy_level = longint'(signed'(value[GAIN_W-1:0]));
            REG_SELL_THRESHOLD: sell_level = longint'(signed'(value[GAIN_W-1:0]));
            REG_HOLD_LIMIT:     hold_limit = int'(value[LIMIT_W-1:0]);
            REG_MARKET_FILTER:  market_filter = value[0];
            default: ;
         endcase
      endfunction

      // round half up of the Q0.16 product
      function longint ema_update(longint e, longint x, longint gain);
         return e + (((x - e) * gain + 32768) >>> FRAC_BITS);
      endfunction

      function int outstanding();
         return expected_signals.size();
      endfunction

      function void note_close(req_payload_type t);
         longint px, dif, dea, lhs;
         rsp_payload_type want;
         bit buy, sell, forced;
         px = longint'(t.close_price);
         buy = 1'b0;
         sell = 1'b0;
         forced = 1'b0;
         want = '0;
         if (t.series_start || phase == PHASE_IDLE) begin
            fast_ema = px;
            slow_ema = px;
            signal_ema = 0;
            prior_dif = 0;
            prior_dea = 0;
            phase = PHASE_FIRST;
            holding = 1'b0;
            hold_count = 0;
         end else begin
            fast_ema = ema_update(fast_ema, px, gain_fast);
            slow_ema = ema_update(slow_ema, px, gain_slow);
            dif = fast_ema - slow_ema;
            if (phase == PHASE_FIRST) begin
               dea = dif;
               phase = PHASE_RUN;
            end else begin
               dea = ema_update(signal_ema, dif, gain_signal);
            end
            signal_ema = dea;
            if (!t.series_last) begin
               lhs = dif * 65536;
               if (!holding) begin
                  if (prior_dif <= prior_dea && dif > dea && lhs < buy_level * px &&
                      (!market_filter || t.market_above)) begin
                     buy = 1'b1;
                     holding = 1'b1;
                     hold_count = 0;
                  end
               end else begin
                  forced = hold_limit != 0 && hold_count >= hold_limit;
                  if ((prior_dif >= prior_dea && dif < dea && lhs > sell_level * px) ||
                      forced) begin
                     sell = 1'b1;
                     holding = 1'b0;
                     hold_count = 0;
                  end
               end
            end
            if (holding && !buy && hold_count < HOLD_MAX)
               hold_count++;
            prior_dif = dif;
            prior_dea = dea;
            want.dif_value = dif[OUT_W-1:0];
            want.dea_value = dea[OUT_W-1:0];
            want.buy_now = buy;
            want.sell_now = sell;
            want.sell_by_limit = sell && forced;
         end
         expected_signals = {expected_signals, want};
      endfunction

      task report_mismatch(string what, longint got, longint want);
         mismatches++;
         $display("result %0d: %s: got %0d, expected %0d", results_seen, what, got, want);
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         results_seen++;
         if (expected_signals.size() == 0) begin
            report_mismatch("result with no transaction pending", 1, 0);
         end else begin
            want = expected_signals.pop_front();
            if (got.dif_value !== want.dif_value)
               report_mismatch("dif_value", longint'(got.dif_value), longint'(want.dif_value));
            if (got.dea_value !== want.dea_value)
               report_mismatch("dea_value", longint'(got.dea_value), longint'(want.dea_value));
            if (got.buy_now !== want.buy_now)
               report_mismatch("buy_now", longint'(got.buy_now), longint'(want.buy_now));
            if (got.sell_now !== want.sell_now)
               report_mismatch("sell_now", longint'(got.sell_now), longint'(want.sell_now));
            if (got.sell_by_limit !== want.sell_by_limit)
               report_mismatch("sell_by_limit", longint'(got.sell_by_limit),
                               longint'(want.sell_by_limit));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int send_idle_pct = 22;
   int stall_pct = 22;
   int periods_sent = 0;
   int cycle_count = 0;

   macd_signal_scoreboard sb = new();

   macd_crossover_signal #(.HOLD_COUNT_BITS(HOLD_COUNT_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("macd_crossover_signal regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_close(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
      end
   end

   task send_period(logic [PRICE_W-1:0] close, logic above, logic start, logic last);
      req_payload_type t;
      t.close_price = close;
      t.market_above = above;
      t.series_start = start;
      t.series_last = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      periods_sent++;
   endtask

   task write_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task wait_for_results();
      req_valid <= 1'b0;
      while (sb.results_seen < periods_sent)
         @(posedge clock);
   endtask

   // first item after reset, zero and full-scale closes, a dip and recovery
   // with a last flag in the middle of the series, then a fall to zero
   task run_directed();
      int unsigned shape[19];
      int i;
      shape = '{100, 96, 92, 88, 84, 86, 90, 95, 101, 108,
                116, 124, 130, 128, 122, 115, 108, 100, 0};
      send_period(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
      send_period(32'h0000_0000, 1'b0, 1'b0, 1'b0);
      send_period(32'h0000_0000, 1'b1, 1'b0, 1'b0);
      send_period(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
      for (i = 0; i < 19; i++)
         send_period(PRICE_W'(shape[i] << 16), i[0], i == 0, i == 9);
   endtask

   task apply_settings(int p);
      logic [GAIN_W-1:0] fast, slow;
      case (p)
         0: begin
            write_register(REG_FAST_GAIN, 32'hFFFF);
            write_register(REG_SLOW_GAIN, 32'hFFFF);
            write_register(REG_SIGNAL_GAIN, 32'hFFFF);
            write_register(REG_BUY_THRESHOLD, 32'h7FFF);
            write_register(REG_SELL_THRESHOLD, 32'h8000);
            write_register(REG_HOLD_LIMIT, 32'd255);
            write_register(REG_MARKET_FILTER, 32'd1);
            write_register(REG_UNMAPPED, $urandom());
         end
         1: begin
            write_register(REG_FAST_GAIN, 32'h0);
            write_register(REG_SLOW_GAIN, 32'h0);
            write_register(REG_SIGNAL_GAIN, 32'h0);
            write_register(REG_BUY_THRESHOLD, 32'h8000);
            write_register(REG_SELL_THRESHOLD, 32'h7FFF);
            write_register(REG_HOLD_LIMIT, 32'd1);
            write_register(REG_MARKET_FILTER, 32'd0);
         end
         2: begin
            write_register(REG_FAST_GAIN, 32'(FAST_GAIN_RESET));
            write_register(REG_SLOW_GAIN, 32'(SLOW_GAIN_RESET));
            write_register(REG_SIGNAL_GAIN, 32'(SIGNAL_GAIN_RESET));
            write_register(REG_BUY_THRESHOLD, 32'h0);
            write_register(REG_SELL_THRESHOLD, 32'h0);
            write_register(REG_HOLD_LIMIT, 32'd0);
            write_register(REG_MARKET_FILTER, 32'd0);
         end
         default: begin
            fast = $urandom_range(0, 3) == 0 ? GAIN_W'($urandom_range(0, 65535))
                                             : GAIN_W'($urandom_range(6000, 30000));
            slow = GAIN_W'($urandom_range(500, 6000));
            write_register(REG_FAST_GAIN, 32'(fast));
            write_register(REG_SLOW_GAIN, 32'(slow));
            write_register(REG_SIGNAL_GAIN, $urandom_range(2000, 40000));
            write_register(REG_BUY_THRESHOLD, $urandom_range(0, 3) == 0 ?
                           $urandom_range(0, 65535) : $urandom_range(0, 2000));
            write_register(REG_SELL_THRESHOLD, $urandom_range(0, 3) == 0 ?
                           $urandom_range(0, 65535) : 32'((-$urandom_range(0, 2000)) & 16'hFFFF));
            write_register(REG_HOLD_LIMIT, $urandom_range(0, 3) == 0 ?
                           $urandom_range(0, 255) : $urandom_range(0, 10));
            write_register(REG_MARKET_FILTER, $urandom_range(0, 1));
         end
      endcase
   endtask

   // series of random-walk closes; a few items carry stray flags or raw closes
   task run_random_phase(int count);
      int sent, len, k;
      longint px, drift, span, noise;
      logic [PRICE_W-1:0] price;
      logic start, last;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 4))
            0: len = 20;
            1: len = 60;
            2: len = 120;
            default: len = $urandom_range(2, 30);
         endcase
         if (len > count - sent)
            len = count - sent;
         px = (longint'($urandom_range(20, 3000)) << 16) | longint'($urandom_range(0, 65535));
         drift = -(px / 64);
         for (k = 0; k < len; k++) begin
            span = px / 32 + 1;
            if ($urandom_range(0, 5) == 0) begin
               drift = longint'($urandom_range(0, 32'(span)));
               if ($urandom_range(0, 1) == 1)
                  drift = -drift;
            end
            noise = longint'($urandom_range(0, 32'(span))) - span / 2;
            px = px + drift + noise;
            if (px < 65536)
               px = 65536;
            if (px > PRICE_MAX)
               px = PRICE_MAX;
            price = px[PRICE_W-1:0];
            start = (k == 0);
            last = (k == len - 1);
            case ($urandom_range(0, 24))
               0: price = $urandom();
               1: start = ~start;
               2: last = ~last;
               default: ;
            endcase
            send_period(price, $urandom_range(0, 1), start, last);
            sent++;
         end
      end
   endtask

   initial begin
      int p;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (p = 0; p < PHASES; p++) begin
         wait_for_results();
         apply_settings(p);
         send_idle_pct = (p == 2) ? 0 : 22;
         stall_pct = (p == 2) ? 0 : 22;
         run_random_phase(PHASE_ITEMS);
      end
      wait_for_results();
      repeat (50) @(posedge clock);
      if (sb.outstanding() != 0)
         sb.report_mismatch("results never delivered", 0, sb.outstanding());
      if (sb.mismatches == 0)
         $display("macd_crossover_signal regression: pass");
      else
         $display("macd_crossover_signal regression: fail");
      $finish;
   end

endmodule

// File: files.f
rtl/core/macdxs_pkg.sv
rtl/core/macd_crossover_signal.sv
dv/macd_crossover_signal_tb.sv
